// ===== src/chtb_pkg.sv =====
`default_nettype none
package chtb_pkg;

  localparam int MAX_ENTRIES  = 1024;
  localparam int BUCKETS      = 256;
  localparam int HEADER_BYTES = 1024;
  localparam int LEN_HDR      = 4;
  localparam int SLOT_DEPTH   = 2 * MAX_ENTRIES;

  localparam int EW = $clog2(MAX_ENTRIES);
  localparam int CW = EW + 1;
  localparam int SW = $clog2(SLOT_DEPTH);
  localparam int LW = SW + 1;
  localparam int BW = $clog2(BUCKETS);

  localparam logic [1:0] REQ_START  = 2'd0;
  localparam logic [1:0] REQ_ADD    = 2'd1;
  localparam logic [1:0] REQ_FINISH = 2'd2;
  localparam logic [1:0] REQ_FETCH  = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_KEY_LONG = 3'd1;
  localparam logic [2:0] ST_VAL_LONG = 3'd2;
  localparam logic [2:0] ST_POS_OVF  = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_PHASE    = 3'd5;

  localparam logic [1:0] KIND_ACK  = 2'd0;
  localparam logic [1:0] KIND_SLOT = 2'd1;
  localparam logic [1:0] KIND_DIR  = 2'd2;
  localparam logic [1:0] KIND_DONE = 2'd3;

  localparam logic [1:0] PH_COLLECT = 2'd0;
  localparam logic [1:0] PH_READOUT = 2'd1;
  localparam logic [1:0] PH_IDLE    = 2'd2;

  localparam logic [4:0] OP_CLR       = 5'd0;
  localparam logic [4:0] OP_IDLE      = 5'd1;
  localparam logic [4:0] OP_DECODE    = 5'd2;
  localparam logic [4:0] OP_ADD_WR    = 5'd3;
  localparam logic [4:0] OP_PFX_RD    = 5'd4;
  localparam logic [4:0] OP_PFX_WR    = 5'd5;
  localparam logic [4:0] OP_GRP_RD    = 5'd6;
  localparam logic [4:0] OP_GRP_FILL  = 5'd7;
  localparam logic [4:0] OP_GRP_WR    = 5'd8;
  localparam logic [4:0] OP_BKT_RD    = 5'd9;
  localparam logic [4:0] OP_BKT_SET   = 5'd10;
  localparam logic [4:0] OP_SCLR      = 5'd11;
  localparam logic [4:0] OP_INS_GRP   = 5'd12;
  localparam logic [4:0] OP_INS_ENT   = 5'd13;
  localparam logic [4:0] OP_INS_DIVST = 5'd14;
  localparam logic [4:0] OP_INS_DIV   = 5'd15;
  localparam logic [4:0] OP_PROBE_RD  = 5'd16;
  localparam logic [4:0] OP_PROBE_CHK = 5'd17;
  localparam logic [4:0] OP_BKT_NEXT  = 5'd18;
  localparam logic [4:0] OP_RESP      = 5'd19;

  typedef struct packed {
    logic [4:0] op;
    logic       accept;
  } cmd_t;

  typedef struct packed {
    logic is_start;
    logic is_add;
    logic is_finish;
    logic err;
    logic last_sweep;
    logic grp_last;
    logic no_entries;
    logic cnt_zero;
    logic sclr_last;
    logic ins_last;
    logic div_done;
    logic slot_used;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ===== src/chtb_mod.sv =====
`default_nettype none
module chtb_mod
  import chtb_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [23:0]   dividend,
  input  wire logic [LW-1:0] divisor,
  output logic      [LW-1:0] rem,
  output logic               done
);

  logic [23:0]   quo_r;
  logic [LW:0]   rem_r;
  logic [LW:0]   trial;
  logic [4:0]    cnt_r;
  logic          busy_r;
  logic          done_r;

  assign trial = {rem_r[LW-1:0], quo_r[23]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 5'd1;
      if (cnt_r == 5'd23) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= {quo_r[22:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem_r <= trial - {1'b0, divisor};
      end else begin
        rem_r <= trial;
      end
    end
  end

  assign rem  = rem_r[LW-1:0];
  assign done = done_r;

endmodule
`default_nettype wire

// ===== src/chtb_ctrl.sv =====
`default_nettype none
module chtb_ctrl
  import chtb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  logic [4:0] state_r;
  logic [4:0] state_nxt;
  logic       resp_pend_r;
  logic       resp_pend_nxt;

  assign in_tready  = (state_r == OP_IDLE);
  assign cmd.op     = state_r;
  assign cmd.accept = in_tvalid && in_tready;

  always_comb begin
    state_nxt     = state_r;
    resp_pend_nxt = resp_pend_r;
    unique case (state_r)
      OP_CLR: begin
        if (sts.last_sweep) begin
          state_nxt     = resp_pend_r ? OP_RESP : OP_IDLE;
          resp_pend_nxt = 1'b0;
        end
      end
      OP_IDLE:      if (cmd.accept) state_nxt = OP_DECODE;
      OP_DECODE: begin
        if (sts.is_start) begin
          state_nxt     = OP_CLR;
          resp_pend_nxt = 1'b1;
        end else if (sts.err) begin
          state_nxt = OP_RESP;
        end else if (sts.is_add) begin
          state_nxt = OP_ADD_WR;
        end else if (sts.is_finish) begin
          state_nxt = OP_PFX_RD;
        end else begin
          state_nxt = OP_RESP;
        end
      end
      OP_ADD_WR:    state_nxt = OP_RESP;
      OP_PFX_RD:    state_nxt = OP_PFX_WR;
      OP_PFX_WR: begin
        if (sts.last_sweep) begin
          state_nxt = sts.no_entries ? OP_BKT_RD : OP_GRP_RD;
        end else begin
          state_nxt = OP_PFX_RD;
        end
      end
      OP_GRP_RD:    state_nxt = OP_GRP_FILL;
      OP_GRP_FILL:  state_nxt = OP_GRP_WR;
      OP_GRP_WR:    state_nxt = sts.grp_last ? OP_BKT_RD : OP_GRP_RD;
      OP_BKT_RD:    state_nxt = OP_BKT_SET;
      OP_BKT_SET:   state_nxt = sts.cnt_zero ? OP_BKT_NEXT : OP_SCLR;
      OP_SCLR:      if (sts.sclr_last) state_nxt = OP_INS_GRP;
      OP_INS_GRP:   state_nxt = OP_INS_ENT;
      OP_INS_ENT:   state_nxt = OP_INS_DIVST;
      OP_INS_DIVST: state_nxt = OP_INS_DIV;
      OP_INS_DIV:   if (sts.div_done) state_nxt = OP_PROBE_RD;
      OP_PROBE_RD:  state_nxt = OP_PROBE_CHK;
      OP_PROBE_CHK: begin
        if (sts.slot_used) begin
          state_nxt = OP_PROBE_RD;
        end else begin
          state_nxt = sts.ins_last ? OP_BKT_NEXT : OP_INS_GRP;
        end
      end
      OP_BKT_NEXT:  state_nxt = sts.last_sweep ? OP_RESP : OP_BKT_RD;
      OP_RESP:      if (sts.out_free) state_nxt = OP_IDLE;
      default:      state_nxt = OP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= OP_CLR;
      resp_pend_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      resp_pend_r <= resp_pend_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/chtb_datapath.sv =====
`default_nettype none
module chtb_datapath
  import chtb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cmd_t        cmd,
  output sts_t             sts,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [24:0] cfg_wdata,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [9:0]  in_key_len,
  input  wire logic [23:0] in_value_len,
  input  wire logic [31:0] in_key_hash,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [1:0]       out_kind,
  output logic [31:0]      out_word_a,
  output logic [31:0]      out_word_b,
  output logic [10:0]      out_item_index,
  output logic             out_last
);

  localparam logic [CW-1:0] MAX_CNT  = CW'(MAX_ENTRIES);
  localparam logic [24:0]   VAL_CAP  = 25'h1000000;
  localparam logic [BW-1:0] LAST_BKT = BW'(BUCKETS - 1);

  // memories
  logic [CW-1:0] mem_cnt   [BUCKETS];
  logic [CW-1:0] mem_start [BUCKETS];
  logic [CW-1:0] mem_fill  [BUCKETS];
  logic [31:0]   mem_tpos  [BUCKETS];
  logic [31:0]   mem_ehash [MAX_ENTRIES];
  logic [31:0]   mem_epos  [MAX_ENTRIES];
  logic [EW-1:0] mem_grp   [MAX_ENTRIES];
  logic [31:0]   mem_shash [SLOT_DEPTH];
  logic [31:0]   mem_spos  [SLOT_DEPTH];
  logic          mem_sused [SLOT_DEPTH];
  logic [10:0]   mem_sidx  [SLOT_DEPTH];

  logic [CW-1:0] cnt_rd, start_rd, fill_rd;
  logic [31:0]   tpos_rd, ehash_rd, epos_rd, shash_rd, spos_rd;
  logic [EW-1:0] grp_rd;
  logic          sused_rd;
  logic [10:0]   sidx_rd;

  logic [BW-1:0] cnt_ra, fill_ra, tpos_ra;
  logic [EW-1:0] ent_ra, grp_ra;
  logic [SW-1:0] slot_ra, fetch_ra;

  // control and build registers
  logic [7:0]    max_key_len_r;
  logic [24:0]   vlim_r;
  logic [1:0]    req_type_r;
  logic [9:0]    key_len_r;
  logic [23:0]   value_len_r;
  logic [31:0]   key_hash_r;
  logic [1:0]    phase_r;
  logic [31:0]   next_pos_r;
  logic [CW-1:0] entry_total_r;
  logic [SW:0]   cursor_r;
  logic [BW-1:0] bi_r;
  logic [CW-1:0] acc_r, u_r, cnt_r, start_r;
  logic [LW-1:0] len_r, k_r, w_r;
  logic [SW-1:0] base_r;
  logic [31:0]   h_r, pos_r;
  logic [2:0]    res_status_r;
  logic [1:0]    res_kind_r;
  logic          out_valid_r;
  logic [2:0]    out_status_r;
  logic [1:0]    out_kind_r;
  logic [31:0]   out_word_a_r, out_word_b_r;
  logic [10:0]   out_item_index_r;
  logic          out_last_r;

  logic [10:0]   klen;
  logic [24:0]   vlen, vlim_eff;
  logic [32:0]   rec_end, fin_end;
  logic [SW:0]   nslots;
  logic [SW:0]   dir_off;
  logic          is_slot;
  logic [2:0]    dec_status;
  logic          load_out;
  logic [LW-1:0] w_inc;
  logic [LW-1:0] rem;
  logic          div_done;

  assign klen     = {1'b0, key_len_r} + 11'd1;
  assign vlen     = {1'b0, value_len_r} + 25'd1;
  assign vlim_eff = (vlim_r > VAL_CAP) ? VAL_CAP : vlim_r;
  assign rec_end  = {1'b0, next_pos_r} + 33'(LEN_HDR) + 33'(klen) + 33'(vlen);
  assign fin_end  = {1'b0, next_pos_r} + {18'b0, entry_total_r, 4'b0};
  assign nslots   = {entry_total_r, 1'b0};
  assign is_slot  = cursor_r < nslots;
  assign dir_off  = cursor_r - nslots;
  assign w_inc    = (w_r + 1'b1 == len_r) ? '0 : w_r + 1'b1;
  assign load_out = (cmd.op == OP_RESP) && (!out_valid_r || out_ready);

  always_comb begin
    dec_status = ST_OK;
    unique case (req_type_r)
      REQ_START: dec_status = ST_OK;
      REQ_ADD: begin
        if (phase_r != PH_COLLECT)       dec_status = ST_PHASE;
        else if (klen > 11'(max_key_len_r)) dec_status = ST_KEY_LONG;
        else if (vlen >= vlim_eff)       dec_status = ST_VAL_LONG;
        else if (entry_total_r >= MAX_CNT) dec_status = ST_FULL;
        else if (rec_end[32])            dec_status = ST_POS_OVF;
        else                             dec_status = ST_OK;
      end
      REQ_FINISH: begin
        if (phase_r != PH_COLLECT) dec_status = ST_PHASE;
        else if (fin_end[32])      dec_status = ST_POS_OVF;
        else                       dec_status = ST_OK;
      end
      REQ_FETCH: dec_status = (phase_r != PH_READOUT) ? ST_PHASE : ST_OK;
      default:   dec_status = ST_OK;
    endcase
  end

  chtb_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.op == OP_INS_DIVST),
    .dividend (ehash_rd[31:8]),
    .divisor  (len_r),
    .rem      (rem),
    .done     (div_done)
  );

  // read addresses
  assign cnt_ra   = (cmd.op == OP_DECODE || cmd.op == OP_ADD_WR) ? key_hash_r[BW-1:0] : bi_r;
  assign fill_ra  = ehash_rd[BW-1:0];
  assign tpos_ra  = dir_off[BW-1:0];
  assign ent_ra   = (cmd.op == OP_GRP_RD || cmd.op == OP_GRP_FILL || cmd.op == OP_GRP_WR)
                    ? u_r[EW-1:0] : grp_rd;
  assign grp_ra   = start_r[EW-1:0] + u_r[EW-1:0];
  assign slot_ra  = base_r + w_r[SW-1:0];
  assign fetch_ra = cursor_r[SW-1:0];

  always_ff @(posedge clk) begin
    cnt_rd   <= mem_cnt[cnt_ra];
    start_rd <= mem_start[bi_r];
    fill_rd  <= mem_fill[fill_ra];
    tpos_rd  <= mem_tpos[tpos_ra];
    ehash_rd <= mem_ehash[ent_ra];
    epos_rd  <= mem_epos[ent_ra];
    grp_rd   <= mem_grp[grp_ra];
    shash_rd <= mem_shash[fetch_ra];
    spos_rd  <= mem_spos[fetch_ra];
    sidx_rd  <= mem_sidx[fetch_ra];
    sused_rd <= mem_sused[slot_ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_CLR) mem_cnt[bi_r] <= '0;
    else if (cmd.op == OP_ADD_WR) mem_cnt[key_hash_r[BW-1:0]] <= cnt_rd + 1'b1;
    if (cmd.op == OP_PFX_WR) begin
      mem_start[bi_r] <= acc_r;
      mem_fill[bi_r]  <= acc_r;
    end else if (cmd.op == OP_GRP_WR) begin
      mem_fill[fill_ra] <= fill_rd + 1'b1;
    end
    if (cmd.op == OP_GRP_WR) mem_grp[fill_rd[EW-1:0]] <= u_r[EW-1:0];
    if (cmd.op == OP_DECODE && req_type_r == REQ_ADD && dec_status == ST_OK) begin
      mem_ehash[entry_total_r[EW-1:0]] <= key_hash_r;
      mem_epos[entry_total_r[EW-1:0]]  <= next_pos_r;
    end
    if (cmd.op == OP_BKT_SET) mem_tpos[bi_r] <= next_pos_r;
    if (cmd.op == OP_SCLR) begin
      mem_shash[base_r + k_r[SW-1:0]] <= '0;
      mem_spos[base_r + k_r[SW-1:0]]  <= '0;
      mem_sused[base_r + k_r[SW-1:0]] <= 1'b0;
      mem_sidx[base_r + k_r[SW-1:0]]  <= 11'(k_r);
    end else if (cmd.op == OP_PROBE_CHK && !sused_rd) begin
      mem_shash[slot_ra] <= h_r;
      mem_spos[slot_ra]  <= pos_r;
      mem_sused[slot_ra] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_key_len_r <= 8'd255;
      vlim_r        <= VAL_CAP;
    end else if (cfg_we) begin
      if (cfg_index) vlim_r <= cfg_wdata;
      else           max_key_len_r <= cfg_wdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_type_r  <= in_req_type;
      key_len_r   <= in_key_len;
      value_len_r <= in_value_len;
      key_hash_r  <= in_key_hash;
    end
    unique case (cmd.op)
      OP_DECODE: begin
        pos_r <= next_pos_r;
        acc_r <= '0;
      end
      OP_PFX_WR: begin
        acc_r <= acc_r + cnt_rd;
      end
      OP_BKT_SET: begin
        cnt_r   <= cnt_rd;
        start_r <= start_rd;
        len_r   <= {cnt_rd, 1'b0};
        base_r  <= {start_rd[SW-2:0], 1'b0};
        k_r     <= '0;
      end
      OP_SCLR:      k_r <= k_r + 1'b1;
      OP_INS_DIVST: begin
        h_r   <= ehash_rd;
        pos_r <= epos_rd;
      end
      OP_INS_DIV:   w_r <= rem;
      OP_PROBE_CHK: if (sused_rd) w_r <= w_inc;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_COLLECT;
      next_pos_r    <= 32'(HEADER_BYTES);
      entry_total_r <= '0;
      cursor_r      <= '0;
      bi_r          <= '0;
      u_r           <= '0;
      res_status_r  <= ST_OK;
      res_kind_r    <= KIND_ACK;
      out_valid_r   <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (cmd.op)
        OP_CLR: bi_r <= bi_r + 1'b1;
        OP_DECODE: begin
          res_status_r <= dec_status;
          res_kind_r   <= KIND_ACK;
          bi_r         <= '0;
          u_r          <= '0;
          if (req_type_r == REQ_START) begin
            phase_r       <= PH_COLLECT;
            next_pos_r    <= 32'(HEADER_BYTES);
            entry_total_r <= '0;
            cursor_r      <= '0;
          end else if (req_type_r == REQ_FINISH && dec_status == ST_POS_OVF) begin
            phase_r <= PH_IDLE;
          end else if (req_type_r == REQ_FETCH && dec_status == ST_OK) begin
            res_kind_r <= is_slot ? KIND_SLOT : KIND_DIR;
          end
        end
        OP_ADD_WR: begin
          next_pos_r    <= rec_end[31:0];
          entry_total_r <= entry_total_r + 1'b1;
        end
        OP_PFX_WR:  bi_r <= bi_r + 1'b1;
        OP_GRP_WR:  u_r  <= u_r + 1'b1;
        OP_BKT_SET: begin
          next_pos_r <= next_pos_r + {17'b0, cnt_rd, 4'b0};
          u_r        <= '0;
        end
        OP_PROBE_CHK: if (!sused_rd) u_r <= u_r + 1'b1;
        OP_BKT_NEXT: begin
          bi_r <= bi_r + 1'b1;
          if (bi_r == LAST_BKT) begin
            phase_r    <= PH_READOUT;
            cursor_r   <= '0;
            res_kind_r <= KIND_DONE;
          end
        end
        OP_RESP: begin
          if (load_out) begin
            out_valid_r <= 1'b1;
            if (req_type_r == REQ_FETCH && res_status_r == ST_OK) begin
              cursor_r <= cursor_r + 1'b1;
              if (res_kind_r == KIND_DIR && dir_off[BW-1:0] == LAST_BKT) phase_r <= PH_IDLE;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status_r     <= res_status_r;
      out_kind_r       <= KIND_ACK;
      out_word_a_r     <= '0;
      out_word_b_r     <= '0;
      out_item_index_r <= '0;
      out_last_r       <= 1'b0;
      if (res_status_r == ST_OK) begin
        out_kind_r <= res_kind_r;
        unique case (res_kind_r)
          KIND_ACK: begin
            if (req_type_r == REQ_ADD) begin
              out_word_a_r <= {vlen[23:0], klen[7:0]};
              out_word_b_r <= pos_r;
            end else begin
              out_word_b_r <= 32'(HEADER_BYTES);
            end
          end
          KIND_SLOT: begin
            out_word_a_r     <= shash_rd;
            out_word_b_r     <= spos_rd;
            out_item_index_r <= sidx_rd;
          end
          KIND_DIR: begin
            out_word_b_r     <= tpos_rd;
            out_item_index_r <= 11'(dir_off[BW-1:0]);
            out_last_r       <= (dir_off[BW-1:0] == LAST_BKT);
          end
          KIND_DONE: out_word_b_r <= next_pos_r;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    sts.is_start   = (req_type_r == REQ_START);
    sts.is_add     = (req_type_r == REQ_ADD);
    sts.is_finish  = (req_type_r == REQ_FINISH);
    sts.err        = (dec_status != ST_OK);
    sts.last_sweep = (bi_r == LAST_BKT);
    sts.grp_last   = (u_r == entry_total_r - 1'b1);
    sts.no_entries = (entry_total_r == '0);
    sts.cnt_zero   = (cnt_rd == '0);
    sts.sclr_last  = (k_r == len_r - 1'b1);
    sts.ins_last   = (u_r == cnt_r - 1'b1);
    sts.div_done   = div_done;
    sts.slot_used  = sused_rd;
    sts.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_kind       = out_kind_r;
  assign out_word_a     = out_word_a_r;
  assign out_word_b     = out_word_b_r;
  assign out_item_index = out_item_index_r;
  assign out_last       = out_last_r;

endmodule
`default_nettype wire

// ===== src/cdb_hash_table_builder.sv =====
// each response is held in an output register until out_tready takes it
// finish: a prefix pass over the buckets, an entry grouping pass, then per bucket a
//   slot clear and, per entry, the 24-step remainder unit and a linear probe
// throughput: one transaction at a time; memories have a write port and a read port
// reset: synchronous active low, then a sweep of all 256 buckets clears their counts
//   before in_tready rises; start runs the same sweep
`default_nettype none
module cdb_hash_table_builder
  import chtb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,  // key_len, value_len, key_hash, zero pad
  input  wire logic [1:0]  in_tuser,  // req_type
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [79:0]      out_tdata, // status, word_a, word_b, item_index, zero pad
  output logic [1:0]       out_tuser, // kind
  output logic             out_tlast,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [24:0] cfg_wdata
);

  cmd_t        cmd;
  sts_t        sts;
  logic [2:0]  status;
  logic [31:0] word_a, word_b;
  logic [10:0] item_index;

  chtb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  chtb_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_req_type    (in_tuser),
    .in_key_len     (in_tdata[9:0]),
    .in_value_len   (in_tdata[33:10]),
    .in_key_hash    (in_tdata[65:34]),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_status     (status),
    .out_kind       (out_tuser),
    .out_word_a     (word_a),
    .out_word_b     (word_b),
    .out_item_index (item_index),
    .out_last       (out_tlast)
  );

  assign out_tdata = {2'b00, item_index, word_b, word_a, status};

endmodule
`default_nettype wire

// ===== src/chtb_checker.sv =====
`default_nettype none
module chtb_checker
  import chtb_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [79:0] out_tdata,
  input wire logic [1:0]  out_tuser,
  input wire logic        out_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output dropped while stalled");

  a_last_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser == KIND_DIR && out_tdata[77:67] == 11'd255)
    else $error("tlast on a transaction other than the final directory entry");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] != ST_OK |->
      out_tuser == KIND_ACK && out_tdata[79:3] == '0 && !out_tlast)
    else $error("error transaction carries data");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:0] != 3'd6 && out_tdata[2:0] != 3'd7)
    else $error("undefined status code");

endmodule

bind cdb_hash_table_builder chtb_checker u_chtb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
`default_nettype wire
